// ===== rtl/spc_pkg.sv =====
// Shared types and constants of the speed PID controller.
package spc_pkg;

    // Fixed datapath widths of the shared multiply-accumulate unit
    localparam int DATA_W  = 32;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 67;
    localparam int OPND_W  = 34;
    localparam int ALPHA_W = 17;
    localparam int DIV_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // Register reset values
    localparam logic signed [DATA_W-1:0] KP_RESET      = 32'sd52428800;
    localparam logic signed [DATA_W-1:0] KI_RESET      = 32'sd65536;
    localparam logic signed [DATA_W-1:0] KD_RESET      = 32'sd0;
    localparam logic signed [DATA_W-1:0] LOW_LIM_RESET = -32'sd1966080000;
    localparam logic signed [DATA_W-1:0] HI_LIM_RESET  = 32'sd1966080000;
    localparam logic [ALPHA_W-1:0]       ALPHA_RESET   = 17'd65536;
    localparam logic [DIV_W-1:0]         DIV_RESET     = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_LOW_LIM = 3'd3,
        CFG_HI_LIM  = 3'd4,
        CFG_ALPHA   = 3'd5,
        CFG_DIV     = 3'd6,
        CFG_ENABLE  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F0,
        S_F1,
        S_F2,
        S_ERR,
        S_SUM,
        S_MHI,
        S_MLO,
        S_MADD,
        S_MTERM,
        S_CLAMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        TERM_I,
        TERM_P,
        TERM_D
    } t_term;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured_speed;
        logic signed [DATA_W-1:0] setpoint_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_value;
        logic                     updated;
        logic signed [DATA_W-1:0] filtered_speed_out;
        logic signed [DATA_W-1:0] integral_term;
    } t_out_item;

endpackage

// ===== rtl/spc_in_if.sv =====
// Input channel of the speed PID controller: one PWM tick per transaction.
interface spc_in_if import spc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spc_out_if.sv =====
// Output channel of the speed PID controller: one result per transaction.
interface spc_out_if import spc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/speed_pid_controller_core.sv =====
// Speed PID controller with low-pass speed filter and anti-windup clamp.
//
// Each input transaction is one PWM tick (raw speed and target speed, signed
// fixed point with FRAC_BITS fraction bits) and returns exactly one result
// transaction. While loop_enable is set the core counts ticks and on every
// update_divider-th tick filters the speed, forms the error, accumulates it
// into a sum saturated at +/-12000, and drives Kp*e + Ki*sum + Kd*(e - last e)
// clamped to the output limits; other ticks report the held values. All
// arithmetic runs through one shared 33x18 signed multiplier with a registered
// product and a 67-bit accumulator, stepped by a small sequencer; each full
// gain product takes two multiplier passes. A no-update tick runs only the
// integral term; an update tick runs filter, error, sum, all three terms and
// the clamp. The next tick is taken once the last result is in the output
// register (ready only while idle), even while that result still waits to be
// taken. Registers are written through a single-cycle write port; the user
// must write them only while the core is idle, which the core does not
// enforce. Writing 0 to loop_enable clears all loop state, and writing either
// output limit clamps the held output into the new range.
module speed_pid_controller_core import spc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    spc_in_if.sink               i_sample,
    spc_out_if.source            o_result
);

    localparam int PID_W = ACC_W - FRAC_BITS + 2;
    localparam longint LIM_RAW = longint'(12000) <<< FRAC_BITS;
    localparam logic signed [OPND_W-1:0] SUM_LIM =
        (LIM_RAW > 64'sd2147483647) ? 34'sd2147483647 : OPND_W'(LIM_RAW);
    localparam logic signed [ACC_W-1:0] INT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] INT_MIN = ACC_W'(-64'sd2147483648);

    // Control state
    t_state                r_state, n_state;
    t_term                 r_term;
    logic                  r_upd;
    logic                  r_out_valid;
    logic [DIV_W-1:0]      r_tick;

    // Configuration registers
    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd, r_lo_lim, r_hi_lim;
    logic [ALPHA_W-1:0]       r_alpha;
    logic [DIV_W-1:0]         r_div;
    logic                     r_enable;

    // Loop state
    logic signed [DATA_W-1:0]   r_smooth;
    logic signed [DATA_W:0]     r_prev;
    logic signed [DATA_W-1:0]   r_esum;
    logic signed [DATA_W-1:0]   r_held;

    // Working registers
    logic signed [DATA_W-1:0]   r_meas, r_target;
    logic signed [DATA_W:0]     r_err;
    logic signed [OPND_W-1:0]   r_diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [PID_W-1:0]    r_pid;
    logic signed [DATA_W-1:0]   r_integ;
    t_out_item                  r_out;

    logic                       w_accept;
    logic                       w_out_load;
    logic [DIV_W-1:0]           w_tick_inc;
    logic                       w_do_upd;
    logic signed [DATA_W-1:0]   w_lo_new, w_hi_new, w_lo_eff, w_hi_eff, w_held_cfg;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [MUL_A_W-1:0]  w_gain;
    logic signed [OPND_W-1:0]   w_opnd;
    logic signed [OPND_W-1:0]   w_esum_wide, w_esum_clamp;
    logic signed [ACC_W-1:0]    w_term;
    logic signed [DATA_W-1:0]   w_term_sat;
    logic signed [PID_W-1:0]    w_pid_lo, w_pid_hi;
    logic [DIV_W-1:0]           w_cfg_div;

    assign w_accept   = i_sample.valid && i_sample.ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
    assign w_tick_inc = r_tick + 16'd1;
    assign w_do_upd   = r_enable && (w_tick_inc >= r_div);

    assign i_sample.ready = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // Effective limits, taking a limit write of this cycle into account
    always_comb begin
        w_lo_new = r_lo_lim;
        w_hi_new = r_hi_lim;
        if (i_cfg_we && (i_cfg_idx == CFG_LOW_LIM)) begin
            w_lo_new = $signed(i_cfg_data);
        end
        if (i_cfg_we && (i_cfg_idx == CFG_HI_LIM)) begin
            w_hi_new = $signed(i_cfg_data);
        end
        if (w_lo_new > w_hi_new) begin
            w_lo_eff = w_hi_new;
            w_hi_eff = w_lo_new;
        end else begin
            w_lo_eff = w_lo_new;
            w_hi_eff = w_hi_new;
        end
        if (r_held < w_lo_eff) begin
            w_held_cfg = w_lo_eff;
        end else if (r_held > w_hi_eff) begin
            w_held_cfg = w_hi_eff;
        end else begin
            w_held_cfg = r_held;
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        case (r_term)
            TERM_I: begin
                w_gain = MUL_A_W'(r_ki);
                w_opnd = OPND_W'(r_esum);
            end
            TERM_P: begin
                w_gain = MUL_A_W'(r_kp);
                w_opnd = OPND_W'(r_err);
            end
            TERM_D: begin
                w_gain = MUL_A_W'(r_kd);
                w_opnd = r_diff;
            end
            default: begin
                w_gain = '0;
                w_opnd = '0;
            end
        endcase

        case (r_state)
            S_F0: begin
                w_mul_a = MUL_A_W'(r_meas);
                w_mul_b = $signed({1'b0, r_alpha});
            end
            S_F1: begin
                w_mul_a = MUL_A_W'(r_smooth);
                w_mul_b = $signed({1'b0, ALPHA_ONE - r_alpha});
            end
            S_MHI: begin
                w_mul_a = w_gain;
                w_mul_b = w_opnd[OPND_W-1:16];
            end
            S_MLO: begin
                w_mul_a = w_gain;
                w_mul_b = $signed({2'b00, w_opnd[15:0]});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Error sum with anti-windup saturation
    always_comb begin
        w_esum_wide = OPND_W'(r_esum) + OPND_W'(r_err);
        if (w_esum_wide > SUM_LIM) begin
            w_esum_clamp = SUM_LIM;
        end else if (w_esum_wide < -SUM_LIM) begin
            w_esum_clamp = -SUM_LIM;
        end else begin
            w_esum_clamp = w_esum_wide;
        end
    end

    // Floor shift of the accumulated product, saturated copy for the integral output
    always_comb begin
        w_term = r_acc >>> FRAC_BITS;
        if (w_term > INT_MAX) begin
            w_term_sat = 32'sh7FFF_FFFF;
        end else if (w_term < INT_MIN) begin
            w_term_sat = 32'sh8000_0000;
        end else begin
            w_term_sat = DATA_W'(w_term);
        end
        w_pid_lo  = PID_W'(w_lo_eff);
        w_pid_hi  = PID_W'(w_hi_eff);
        w_cfg_div = i_cfg_data[DIV_W-1:0];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_do_upd ? S_F0 : S_MHI;
                end
            end
            S_F0:   n_state = S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_ERR;
            S_ERR:  n_state = S_SUM;
            S_SUM:  n_state = S_MHI;
            S_MHI:  n_state = S_MLO;
            S_MLO:  n_state = S_MADD;
            S_MADD: n_state = S_MTERM;
            S_MTERM: begin
                if (!r_upd) begin
                    n_state = S_DONE;
                end else if (r_term == TERM_D) begin
                    n_state = S_CLAMP;
                end else begin
                    n_state = S_MHI;
                end
            end
            S_CLAMP: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Shared multiplier, product registered every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Datapath and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term      <= TERM_I;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_kp        <= KP_RESET;
            r_ki        <= KI_RESET;
            r_kd        <= KD_RESET;
            r_lo_lim    <= LOW_LIM_RESET;
            r_hi_lim    <= HI_LIM_RESET;
            r_alpha     <= ALPHA_RESET;
            r_div       <= DIV_RESET;
            r_enable    <= 1'b0;
            r_smooth    <= '0;
            r_prev      <= '0;
            r_esum      <= '0;
            r_held      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_meas   <= i_sample.data.measured_speed;
                        r_target <= i_sample.data.setpoint_speed;
                        r_upd    <= w_do_upd;
                        r_term   <= TERM_I;
                        if (r_enable) begin
                            r_tick <= w_do_upd ? '0 : w_tick_inc;
                        end
                    end
                end
                S_F1: r_acc <= ACC_W'(r_prod);
                S_F2: r_acc <= r_acc + ACC_W'(r_prod);
                S_ERR: begin
                    r_smooth <= $signed(r_acc[47:16]);
                    r_err    <= (DATA_W+1)'(r_target) - (DATA_W+1)'($signed(r_acc[47:16]));
                end
                S_SUM: begin
                    r_esum <= DATA_W'(w_esum_clamp);
                    r_diff <= OPND_W'(r_err) - OPND_W'(r_prev);
                    r_prev <= r_err;
                end
                S_MLO:  r_acc <= ACC_W'(r_prod) <<< 16;
                S_MADD: r_acc <= r_acc + ACC_W'(r_prod);
                S_MTERM: begin
                    // Integral term first: it also feeds the integral output
                    if (r_term == TERM_I) begin
                        r_pid   <= PID_W'(w_term);
                        r_integ <= w_term_sat;
                        r_term  <= TERM_P;
                    end else begin
                        r_pid  <= r_pid + PID_W'(w_term);
                        r_term <= TERM_D;
                    end
                end
                S_CLAMP: begin
                    if (r_pid < w_pid_lo) begin
                        r_held <= w_lo_eff;
                    end else if (r_pid > w_pid_hi) begin
                        r_held <= w_hi_eff;
                    end else begin
                        r_held <= DATA_W'(r_pid);
                    end
                end
                default: ;
            endcase

            // Output register: load the finished result, drop it once taken
            if (w_out_load) begin
                r_out.drive_value        <= r_held;
                r_out.updated            <= r_upd;
                r_out.filtered_speed_out <= r_smooth;
                r_out.integral_term      <= r_integ;
                r_out_valid              <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KP:      r_kp <= $signed(i_cfg_data);
                    CFG_KI:      r_ki <= $signed(i_cfg_data);
                    CFG_KD:      r_kd <= $signed(i_cfg_data);
                    CFG_LOW_LIM: begin
                        r_lo_lim <= $signed(i_cfg_data);
                        r_held   <= w_held_cfg;
                    end
                    CFG_HI_LIM: begin
                        r_hi_lim <= $signed(i_cfg_data);
                        r_held   <= w_held_cfg;
                    end
                    CFG_ALPHA: begin
                        // Saturate weights above unity
                        if (i_cfg_data[ALPHA_W-1:0] > ALPHA_ONE) begin
                            r_alpha <= ALPHA_ONE;
                        end else begin
                            r_alpha <= i_cfg_data[ALPHA_W-1:0];
                        end
                    end
                    CFG_DIV: begin
                        // A zero divider runs an update on every tick
                        if (w_cfg_div == '0) begin
                            r_div <= 16'd1;
                        end else begin
                            r_div <= w_cfg_div;
                        end
                    end
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_smooth <= '0;
                            r_prev   <= '0;
                            r_esum   <= '0;
                            r_held   <= '0;
                            r_tick   <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted tick did not start the sequencer");

    a_esum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OPND_W'(r_esum) <= SUM_LIM) && (OPND_W'(r_esum) >= -SUM_LIM))
        else $error("error sum outside its anti-windup limit");

    a_filter_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F0) |-> r_upd)
        else $error("filter step entered on a tick without update");

    a_done_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished result not presented");

endmodule

// ===== test/spc_result_checker.sv =====
// Result checker for the speed PID controller: models the loop and compares every result.
`timescale 1ns / 100ps
module spc_result_checker import spc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    spc_in_if                    i_tick_mon,
    spc_out_if                   i_res_mon,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_updates
);

    localparam longint WORD_MAX    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WORD_MIN    = -64'sh0000_0000_8000_0000;
    localparam longint SUM_CAP_RAW = longint'(12000) <<< FRAC_BITS;
    localparam longint SUM_CAP     = (SUM_CAP_RAW > WORD_MAX) ? WORD_MAX : SUM_CAP_RAW;
    localparam int     REPORT_MAX  = 10;

    // Register copy
    logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, lim_a, lim_b;
    logic [ALPHA_W-1:0]       alpha_q;
    logic [DIV_W-1:0]         divider_q;
    logic                     loop_on;

    // Loop state
    logic signed [DATA_W-1:0] smooth_spd, err_acc, drive_hold;
    logic signed [DATA_W:0]   last_err;
    logic [DIV_W-1:0]         tick_cnt;

    t_out_item awaited_results[$];

    function automatic logic signed [DATA_W-1:0] clamp_word(input longint v, input longint lo,
                                                            input longint hi);
        if (v < lo) return lo[DATA_W-1:0];
        if (v > hi) return hi[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    // Full gain product, floored back to the fixed-point scale
    function automatic longint gain_product(input logic signed [DATA_W-1:0] gain,
                                            input logic signed [OPND_W-1:0] opnd);
        logic signed [DATA_W+OPND_W-1:0] full;
        full = gain * opnd;
        return longint'(full >>> FRAC_BITS);
    endfunction

    // The smaller limit always acts as the lower bound
    function automatic void effective_limits(output longint lo, output longint hi);
        if (lim_a > lim_b) begin
            lo = lim_b;
            hi = lim_a;
        end else begin
            lo = lim_a;
            hi = lim_b;
        end
    endfunction

    function automatic void clear_loop_state();
        smooth_spd = '0;
        last_err   = '0;
        err_acc    = '0;
        drive_hold = '0;
        tick_cnt   = '0;
    endfunction

    function automatic void write_register(input t_cfg_idx idx, input logic [DATA_W-1:0] value);
        longint lo, hi;
        case (idx)
            CFG_KP: kp_q = value;
            CFG_KI: ki_q = value;
            CFG_KD: kd_q = value;
            CFG_LOW_LIM, CFG_HI_LIM: begin
                if (idx == CFG_LOW_LIM) lim_a = value;
                else lim_b = value;
                effective_limits(lo, hi);
                drive_hold = clamp_word(drive_hold, lo, hi);
            end
            CFG_ALPHA: begin
                alpha_q = (value[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : value[ALPHA_W-1:0];
            end
            CFG_DIV: begin
                divider_q = (value[DIV_W-1:0] == '0) ? 16'd1 : value[DIV_W-1:0];
            end
            CFG_ENABLE: begin
                loop_on = value[0];
                if (!value[0]) clear_loop_state();
            end
            default: ;
        endcase
    endfunction

    // Advance the loop by one PWM tick and return the result it must produce
    function automatic t_out_item predict_tick(input t_in_item tick);
        longint    lo, hi, mix, err, total;
        t_out_item res;
        res.updated = 1'b0;
        if (loop_on) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= divider_q) begin
                tick_cnt   = '0;
                mix        = longint'(alpha_q) * longint'($signed(tick.measured_speed))
                           + longint'(ALPHA_ONE - alpha_q) * longint'(smooth_spd);
                smooth_spd = mix[47:16];
                err        = longint'($signed(tick.setpoint_speed)) - longint'(smooth_spd);
                err_acc    = clamp_word(longint'(err_acc) + err, -SUM_CAP, SUM_CAP);
                total      = gain_product(kp_q, err[OPND_W-1:0])
                           + gain_product(ki_q, OPND_W'(err_acc))
                           + gain_product(kd_q, OPND_W'(err - longint'(last_err)));
                effective_limits(lo, hi);
                drive_hold  = clamp_word(total, lo, hi);
                last_err    = err[DATA_W:0];
                res.updated = 1'b1;
            end
        end
        res.drive_value        = drive_hold;
        res.filtered_speed_out = smooth_spd;
        res.integral_term      = clamp_word(gain_product(ki_q, OPND_W'(err_acc)),
                                            WORD_MIN, WORD_MAX);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item got, want;
        if (!i_rst_n) begin
            kp_q      = KP_RESET;
            ki_q      = KI_RESET;
            kd_q      = KD_RESET;
            lim_a     = LOW_LIM_RESET;
            lim_b     = HI_LIM_RESET;
            alpha_q   = ALPHA_RESET;
            divider_q = DIV_RESET;
            loop_on   = 1'b0;
            clear_loop_state();
            awaited_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_checked    = 0;
            o_updates    = 0;
        end else begin
            if (i_cfg_we) write_register(t_cfg_idx'(i_cfg_idx), i_cfg_data);

            // Compare before queuing: a tick accepted this edge cannot answer yet
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = i_res_mon.data;
                if (awaited_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("%0t: unexpected result drive=%h upd=%b filt=%h integ=%h",
                                 $realtime, got.drive_value, got.updated,
                                 got.filtered_speed_out, got.integral_term);
                end else begin
                    want = awaited_results.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $write("%0t: result %0d mismatch: expected drive=%h upd=%b ",
                                   $realtime, o_checked, want.drive_value, want.updated);
                            $write("filt=%h integ=%h, ",
                                   want.filtered_speed_out, want.integral_term);
                            $display("got drive=%h upd=%b filt=%h integ=%h",
                                     got.drive_value, got.updated,
                                     got.filtered_speed_out, got.integral_term);
                        end
                    end
                end
            end

            if (i_tick_mon.valid && i_tick_mon.ready) begin
                want = predict_tick(i_tick_mon.data);
                if (want.updated) o_updates++;
                awaited_results.push_back(want);
            end
            o_pending = awaited_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the speed PID controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top import spc_pkg::*; ();

    localparam int FRAC_BITS   = 16;
    localparam int LONG_HOLD   = 300;   // cycles the result side holds off once
    localparam int DRAIN_LIMIT = 5000;  // cycles allowed for the last results
    localparam int SETTLE      = 30;    // wait after the drain for any stray result
    localparam int PHASES      = 12;
    localparam int PHASE_TICKS = 37;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;

    int fail_count, pending, checked, updates;
    int ticks_sent, reg_writes, settings_seen;
    bit quiet;           // no idling on either side from here on
    bit long_hold_req;   // raised once by the stimulus to ask for the long stall
    bit long_hold_done;  // owned by the result side
    bit loop_running;    // stimulus-side view of loop_enable

    spc_in_if  tick_ch();
    spc_out_if res_ch();

    speed_pid_controller_core #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (tick_ch),
        .o_result   (res_ch)
    );

    spc_result_checker #(.FRAC_BITS(FRAC_BITS)) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_tick_mon   (tick_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_updates    (updates)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Value pickers. Extremes, zero and full-range words show up often
    // enough that every bit toggles; most values stay in a narrow signed
    // band so the loop output is not pinned to a limit all the time.
    // ------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pick_word(input int bits);
        logic signed [DATA_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3, 4:    return r;
            default: return (r <<< (DATA_W - bits)) >>> (DATA_W - bits);
        endcase
    endfunction

    // Filter weight, with junk in the unused upper bits of the write data
    function automatic logic [DATA_W-1:0] pick_alpha();
        logic [DATA_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0:       return {r[DATA_W-1:ALPHA_W], 17'd0};
            1:       return {r[DATA_W-1:ALPHA_W], ALPHA_ONE};
            2:       return {r[DATA_W-1:ALPHA_W], 1'b1, r[15:1], 1'b1};  // above one
            default: return {r[DATA_W-1:ALPHA_W], 17'($urandom_range(0, 65536))};
        endcase
    endfunction

    // Mostly short dividers so updates come often; zero and the maximum now and then
    function automatic logic [DATA_W-1:0] pick_divider();
        logic [DATA_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0:       return {r[DATA_W-1:DIV_W], 16'd0};
            1:       return {r[DATA_W-1:DIV_W], 16'hFFFF};
            2:       return {r[DATA_W-1:DIV_W], 16'($urandom_range(1, 40))};
            default: return {r[DATA_W-1:DIV_W], 16'($urandom_range(1, 4))};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes on the falling edge and each signal
    // gets at most one assignment per falling edge.
    // ------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        reg_writes++;
    endtask

    // Offer one tick, after an optional idle burst, and hold it until taken.
    // valid stays high on return so back-to-back ticks need no gap.
    task automatic send_tick(input logic [DATA_W-1:0] meas, input logic [DATA_W-1:0] tgt,
                             input int gap_pct);
        int gap;
        if (!quiet && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge i_clk);
                tick_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= '{measured_speed: meas, setpoint_speed: tgt};
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    // Drop valid, then wait for every outstanding result so registers may change
    task automatic settle();
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // One block of random ticks under a freshly shuffled setting
    task automatic random_phase(input bit with_pressure);
        logic [DATA_W-1:0] r, meas, tgt, delta;
        int                gap_pct;
        r = $urandom();
        settle();
        settings_seen++;
        if ($urandom_range(0, 1)) write_reg(CFG_KP, pick_word(22));
        if ($urandom_range(0, 1)) write_reg(CFG_KI, pick_word(20));
        if ($urandom_range(0, 1)) write_reg(CFG_KD, pick_word(20));
        if ($urandom_range(0, 1)) write_reg(CFG_LOW_LIM, pick_word(28));
        if ($urandom_range(0, 1)) write_reg(CFG_HI_LIM, pick_word(28));
        if ($urandom_range(0, 1)) write_reg(CFG_ALPHA, pick_alpha());
        if ($urandom_range(0, 1)) write_reg(CFG_DIV, pick_divider());

        // Keep the loop running most of the time; clear it now and then
        case ($urandom_range(0, 7))
            0: begin
                write_reg(CFG_ENABLE, {r[DATA_W-1:1], 1'b0});
                loop_running = 1'b0;
            end
            1: begin
                write_reg(CFG_ENABLE, '0);
                write_reg(CFG_ENABLE, {r[DATA_W-1:1], 1'b1});
                loop_running = 1'b1;
            end
            default: begin
                if (!loop_running) begin
                    write_reg(CFG_ENABLE, {r[DATA_W-1:1], 1'b1});
                    loop_running = 1'b1;
                end
            end
        endcase

        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        if (with_pressure) long_hold_req = 1'b1;

        repeat (PHASE_TICKS) begin
            meas  = pick_word(20);
            delta = $urandom();
            // Target mostly tracks the speed closely; sometimes anywhere
            if ($urandom_range(0, 3) == 0) tgt = pick_word(20);
            else tgt = meas + {{16{delta[15]}}, delta[15:0]};
            send_tick(meas, tgt, gap_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, long ready stretches, and one long
    // hold-off so the block fills up and pushes back on the tick side.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int span;
        bit hold;
        res_ch.ready = 1'b0;
        forever begin
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                for (int k = 0; k < LONG_HOLD; k++) begin
                    @(negedge i_clk);
                    res_ch.ready <= 1'b0;
                end
            end else begin
                span = $urandom_range(1, 16);
                hold = !quiet && ($urandom_range(0, 3) == 0);
                if (!hold && $urandom_range(0, 7) == 0) span = 64;
                for (int k = 0; k < span; k++) begin
                    @(negedge i_clk);
                    res_ch.ready <= !hold;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        int wait_cnt;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_KP;
        cfg_data      = '0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        loop_running  = 1'b0;
        ticks_sent    = 0;
        reg_writes    = 0;
        settings_seen = 1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Loop is off out of reset: ticks report the cleared state, no update
        send_tick(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_tick(32'h7FFF_FFFF, 32'h8000_0000, 0);
        settle();

        // Default gains with a divider of ten: the tenth tick runs the first update
        write_reg(CFG_ENABLE, 32'd1);
        loop_running = 1'b1;
        for (int k = 0; k < 10; k++)
            send_tick(32'(k) << 14, 32'h0003_0000, 0);
        settle();

        // A new limit clamps the held output at once; inverted limits swap
        write_reg(CFG_HI_LIM, 32'h0064_0000);
        write_reg(CFG_LOW_LIM, 32'h7FFF_FFFF);
        send_tick(32'h0001_0000, 32'h0002_0000, 0);
        settle();

        // Count up under the largest divider, then lower it below the count
        write_reg(CFG_DIV, 32'hABCD_FFFF);
        repeat (3) send_tick(32'hFFFF_0000, 32'h0000_8000, 0);
        settle();
        write_reg(CFG_DIV, 32'd2);
        send_tick(32'h0004_0000, 32'hFFFC_0000, 0);
        settle();

        // Disable clears the loop; then the most violent setting: extreme
        // gains, full limits, weight above one, zero divider
        write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
        write_reg(CFG_KP, 32'h7FFF_FFFF);
        write_reg(CFG_KI, 32'h7FFF_FFFF);
        write_reg(CFG_KD, 32'h8000_0000);
        write_reg(CFG_LOW_LIM, 32'h8000_0000);
        write_reg(CFG_HI_LIM, 32'h7FFF_FFFF);
        write_reg(CFG_ALPHA, 32'h0001_FFFF);
        write_reg(CFG_DIV, 32'hFFFF_0000);
        write_reg(CFG_ENABLE, 32'd1);
        // Drive the error sum into saturation, then swing the error hard the other way
        repeat (3) send_tick(32'h8000_0000, 32'h7FFF_FFFF, 0);
        repeat (2) send_tick(32'h7FFF_FFFF, 32'h8000_0000, 0);
        settle();

        // Zero weight freezes the filter; re-enabling clears nothing
        write_reg(CFG_ALPHA, 32'd0);
        send_tick(32'h1234_5678, 32'h0000_0000, 0);
        settle();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_ALPHA, 32'd1);
        send_tick(32'h7FFF_FFFF, 32'h0000_0000, 0);
        send_tick(32'h8000_0000, 32'hFFFF_FFFF, 0);
        settings_seen += 6;

        // Random part; the long stall lands in the third block, and the
        // last two blocks run without idling on either side
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 2) quiet = 1'b1;
            random_phase(ph == 2);
        end
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        for (wait_cnt = 0; pending != 0 && wait_cnt < DRAIN_LIMIT; wait_cnt++)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Run covered %0d ticks, %0d results checked, %0d of them loop updates.",
                 ticks_sent, checked, updates);
        $display("%0d register writes over %0d settings, with one %0d-cycle result stall.",
                 reg_writes, settings_seen, LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
